// ===== hw/rtl/first_fit_block_allocator_top_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Included by ffba_seq and first_fit_block_allocator_top; no other dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ffba_pkg.sv =====
// Package for the first-fit block allocator: widths, codes, defaults and
// the request and response types. No dependencies.
`default_nettype none

package ffba_pkg;

	localparam int SIZE_W = 24;
	localparam int NEED_W = SIZE_W + 1;
	localparam int TOT_W  = SIZE_W + 2;
	localparam int STAT_W = 2;

	localparam int DEF_MAX_BLOCKS  = 64;
	localparam int DEF_ALIGN_BYTES = 16;
	localparam int DEF_HDR_BYTES   = 32;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOOP    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADADDR = 2'd3;

	typedef struct packed {
		logic              func;
		logic [SIZE_W-1:0] request_size;
		logic [SIZE_W-1:0] release_addr;
	} req_t;

	typedef struct packed {
		logic [SIZE_W-1:0] payload_addr;
		logic [STAT_W-1:0] status;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffba_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffba_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ffba_align.sv =====
// Round-up unit: rounds a request size up to a multiple of the alignment, by a
// registered reciprocal multiplication and multiply back. Depends on ffba_pkg.
`default_nettype none

module ffba_align
	import ffba_pkg::*;
#(
	parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SIZE_W-1:0] value,
	output logic                   done,
	output logic      [NEED_W-1:0] result
);

	localparam int LG = $clog2(ALIGN_BYTES);
	localparam int MW = NEED_W + 1;
	localparam int SH = NEED_W + LG;
	localparam int PW = NEED_W + MW;
	localparam int QW = PW - SH;
	localparam int AW = $clog2(ALIGN_BYTES + 1);
	localparam int BW = QW + AW;

	localparam logic [63:0]       RECIP_L = ((64'd1 << SH) + 64'(ALIGN_BYTES - 1))
		/ 64'(ALIGN_BYTES);
	localparam logic [MW-1:0]     RECIP   = RECIP_L[MW-1:0];
	localparam logic [NEED_W-1:0] BIAS    = NEED_W'(ALIGN_BYTES - 1);
	localparam logic [AW-1:0]     ALIGN_A = AW'(ALIGN_BYTES);

	logic              go_q;
	logic              done_q;
	logic [QW-1:0]     quot_q;
	logic [NEED_W-1:0] result_q;
	logic [NEED_W-1:0] biased;
	logic [PW-1:0]     prod;
	logic [BW-1:0]     back;

	assign biased = {1'b0, value} + BIAS;
	assign prod   = PW'(biased) * PW'(RECIP);
	assign back   = BW'(quot_q) * BW'(ALIGN_A);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q     <= 1'b0;
			done_q   <= 1'b0;
			quot_q   <= '0;
			result_q <= '0;
		end else begin
			go_q   <= start;
			done_q <= go_q;
			if (start) begin
				quot_q <= prod[PW-1:SH];
			end
			if (go_q) begin
				result_q <= NEED_W'(back);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ffba_seq.sv =====
// Allocator sequencer: block table RAM, scan, merge and compaction passes.
// Depends on ffba_pkg, ffba_ram, ffba_align and the shared assertion macros.
`default_nettype none
`include "first_fit_block_allocator_top_defines.svh"

module ffba_seq
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
	parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
	parameter int HDR_BYTES   = DEF_HDR_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire req_t              req,
	input  wire logic [SIZE_W-1:0] heap_limit,
	output logic                   idle,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output rsp_t                   rsp
);

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int ENT_W  = SIZE_W + 1;
	localparam int GROW_W = TOT_W + 1;
	localparam int HDR_ALIGNED = ((HDR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

	localparam logic [NEED_W-1:0] HDR_N  = NEED_W'(HDR_BYTES);
	localparam logic [TOT_W-1:0]  HDR_T  = TOT_W'(HDR_BYTES);
	localparam logic [TOT_W-1:0]  HDRA_T = TOT_W'(HDR_ALIGNED);
	localparam logic [CNT_W-1:0]  MAX_C  = CNT_W'(MAX_BLOCKS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALIGN = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FWD   = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]        state_q;
	logic              func_q;
	logic [SIZE_W-1:0] rel_q;
	logic [NEED_W-1:0] need_q;
	logic [CNT_W-1:0]  idx_q;
	logic              chk_v_q;
	logic [IDX_W-1:0]  chk_idx_q;
	logic [SIZE_W-1:0] off_q;
	logic              prev_v_q;
	logic              prev_free_q;
	logic [SIZE_W-1:0] prev_size_q;
	logic [IDX_W-1:0]  base_q;
	logic [SIZE_W-1:0] acc_q;
	logic [CNT_W-1:0]  dst_q;
	logic [CNT_W-1:0]  count_q;
	logic [SIZE_W-1:0] heap_used_q;
	rsp_t              rsp_q;

	logic              align_start;
	logic              align_done;
	logic [NEED_W-1:0] align_result;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic [ENT_W-1:0]  rd_data;

	logic              issue;
	logic [SIZE_W-1:0] ent_size;
	logic              ent_free;
	logic [NEED_W-1:0] off_hdr;
	logic [SIZE_W-1:0] off_step;
	logic [SIZE_W-1:0] acc_step;
	logic              alloc_hit;
	logic              rel_hit;
	logic              scan_end;
	logic [TOT_W-1:0]  total;
	logic [GROW_W-1:0] grow;
	logic              full;
	logic              over;
	logic              append_ok;
	logic [SIZE_W-1:0] new_size;
	logic              fwd_go;
	logic              merge_prev;
	logic [IDX_W-1:0]  p_idx;
	logic [CNT_W-1:0]  p_next;
	logic [CNT_W-1:0]  k_cnt;
	logic [SIZE_W-1:0] merged;

	assign issue     = idx_q < count_q;
	assign ent_size  = rd_data[SIZE_W-1:0];
	assign ent_free  = rd_data[SIZE_W];
	assign off_hdr   = {1'b0, off_q} + HDR_N;
	assign off_step  = SIZE_W'(off_hdr + {1'b0, ent_size});
	assign acc_step  = SIZE_W'({1'b0, acc_q} + HDR_N + {1'b0, ent_size});
	assign alloc_hit = chk_v_q && (func_q == FUNC_ALLOC) && ent_free
		&& ({1'b0, ent_size} >= need_q);
	assign rel_hit   = chk_v_q && (func_q == FUNC_FREE) && (off_hdr == {1'b0, rel_q});
	assign scan_end  = !chk_v_q && !issue;
	assign total     = {1'b0, need_q} + HDRA_T;
	assign grow      = GROW_W'(heap_used_q) + GROW_W'(total);
	assign full      = count_q == MAX_C;
	assign over      = grow > GROW_W'(heap_limit);
	assign append_ok = (func_q == FUNC_ALLOC) && !full && !over;
	assign new_size  = SIZE_W'(total - HDR_T);
	assign fwd_go    = chk_v_q && ent_free;
	assign merge_prev = prev_v_q && prev_free_q;
	assign p_idx     = merge_prev ? base_q - IDX_W'(1) : base_q;
	assign p_next    = CNT_W'(p_idx) + CNT_W'(1);
	assign k_cnt     = chk_v_q ? CNT_W'(chk_idx_q) : count_q;
	assign merged    = merge_prev ? SIZE_W'({1'b0, prev_size_q} + HDR_N + {1'b0, acc_q}) : acc_q;

	assign align_start = (state_q == S_IDLE) && req_valid && (req.func == FUNC_ALLOC)
		&& (req.request_size != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = chk_idx_q;
		wr_data = {1'b0, ent_size};
		unique case (state_q)
			S_SCAN: begin
				if (alloc_hit) begin
					wr_en = 1'b1;
				end else if (!chk_v_q && scan_end && append_ok) begin
					wr_en   = 1'b1;
					wr_addr = count_q[IDX_W-1:0];
					wr_data = {1'b0, new_size};
				end
			end
			S_FWD: begin
				if (!fwd_go) begin
					wr_en   = 1'b1;
					wr_addr = p_idx;
					wr_data = {1'b1, merged};
				end
			end
			S_CMP: begin
				if (chk_v_q) begin
					wr_en   = 1'b1;
					wr_addr = dst_q[IDX_W-1:0];
					wr_data = rd_data;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	ffba_align #(
		.ALIGN_BYTES(ALIGN_BYTES)
	) u_align (
		.clk   (clk),
		.arst_n(arst_n),
		.start (align_start),
		.value (req.request_size),
		.done  (align_done),
		.result(align_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= FUNC_ALLOC;
			rel_q       <= '0;
			need_q      <= '0;
			idx_q       <= '0;
			chk_v_q     <= 1'b0;
			chk_idx_q   <= '0;
			off_q       <= '0;
			prev_v_q    <= 1'b0;
			prev_free_q <= 1'b0;
			prev_size_q <= '0;
			base_q      <= '0;
			acc_q       <= '0;
			dst_q       <= '0;
			count_q     <= '0;
			heap_used_q <= '0;
			rsp_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q   <= req.func;
						rel_q    <= req.release_addr;
						idx_q    <= '0;
						chk_v_q  <= 1'b0;
						off_q    <= '0;
						prev_v_q <= 1'b0;
						rsp_q    <= '{payload_addr: '0, status: ST_NOOP};
						if (req.func == FUNC_ALLOC) begin
							state_q <= (req.request_size == '0) ? S_RESP : S_ALIGN;
						end else begin
							state_q <= (req.release_addr == '0) ? S_RESP : S_SCAN;
						end
					end
				end
				S_ALIGN: begin
					if (align_done) begin
						need_q  <= align_result;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					chk_v_q <= issue;
					if (issue) begin
						idx_q     <= idx_q + CNT_W'(1);
						chk_idx_q <= idx_q[IDX_W-1:0];
					end
					if (alloc_hit) begin
						rsp_q   <= '{payload_addr: SIZE_W'(off_hdr), status: ST_OK};
						state_q <= S_RESP;
					end else if (rel_hit) begin
						acc_q   <= ent_size;
						base_q  <= chk_idx_q;
						state_q <= S_FWD;
					end else if (chk_v_q) begin
						off_q       <= off_step;
						prev_size_q <= ent_size;
						prev_free_q <= ent_free;
						prev_v_q    <= 1'b1;
					end else if (scan_end) begin
						state_q <= S_RESP;
						if (func_q == FUNC_FREE) begin
							rsp_q <= '{payload_addr: '0, status: ST_BADADDR};
						end else if (!append_ok) begin
							rsp_q <= '{payload_addr: '0, status: ST_NOMEM};
						end else begin
							rsp_q <= '{payload_addr: SIZE_W'({1'b0, heap_used_q} + HDR_N),
								status: ST_OK};
							count_q     <= count_q + CNT_W'(1);
							heap_used_q <= SIZE_W'(grow);
						end
					end
				end
				S_FWD: begin
					if (issue) begin
						chk_idx_q <= idx_q[IDX_W-1:0];
					end
					if (fwd_go) begin
						chk_v_q <= issue;
						acc_q   <= acc_step;
						if (issue) begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end else begin
						rsp_q   <= '{payload_addr: '0, status: ST_OK};
						chk_v_q <= 1'b0;
						if (k_cnt == p_next) begin
							state_q <= S_RESP;
						end else begin
							dst_q   <= p_next;
							idx_q   <= k_cnt;
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					chk_v_q <= issue;
					if (issue) begin
						idx_q     <= idx_q + CNT_W'(1);
						chk_idx_q <= idx_q[IDX_W-1:0];
					end
					if (chk_v_q) begin
						dst_q <= dst_q + CNT_W'(1);
					end else if (!issue) begin
						count_q <= dst_q;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_RESP;
	assign rsp       = rsp_q;

	`FFBA_ASSERT_IMP(a_cmp_dst_below_src, clk, arst_n, (state_q == S_CMP) && chk_v_q, dst_q < idx_q, "compaction write overtakes read")
	`FFBA_ASSERT_IMP(a_chk_in_table, clk, arst_n, ((state_q == S_SCAN) || (state_q == S_FWD)) && chk_v_q, CNT_W'(chk_idx_q) < count_q, "table read beyond entry count")
	`FFBA_ASSERT_NXT(a_append_count, clk, arst_n, (state_q == S_SCAN) && scan_end && append_ok, count_q == $past(count_q) + CNT_W'(1), "append did not grow table")

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_block_allocator_top.sv =====
// First-fit block allocator with coalescing.
//
// Slave stream carries one request per transfer: tuser is the function (allocate
// or release), tdata the request size and the release address. Master stream
// carries one result per transfer: tdata the payload offset, tuser the status.
// The heap limit register is written through cfg_we / cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce.
//
// One request is in flight at a time; s_tready is high only while the sequencer
// waits for work. The block table is scanned through a single RAM read port, one
// entry per cycle. An allocate rounds the size up, then scans; a release scans
// for the address, absorbs free successors and a free predecessor, then shifts
// the later entries down over the absorbed ones. Zero-size and null requests
// skip the scan and answer with the no-op status.
// A result sits in the output register; the next request is accepted while it
// waits, and the sequencer holds its following result until the slot drains.
// Reset empties the table, clears the heap and sets the limit to all ones.
// Depends on ffba_pkg, ffba_seq and the shared assertion macros.
`default_nettype none
`include "first_fit_block_allocator_top_defines.svh"

module first_fit_block_allocator_top
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
	parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
	parameter int HDR_BYTES   = DEF_HDR_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // request_size[23:0], release_addr[47:24]
	input  wire logic [0:0]  s_tuser,   // func[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // payload_addr[23:0]
	output logic      [1:0]  m_tuser,   // status[1:0]
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata
);

	logic              m_tvalid_q;
	rsp_t              out_q;
	logic [SIZE_W-1:0] heap_limit_q;
	logic              seq_idle;
	logic              res_valid;
	logic              res_ready;
	rsp_t              rsp;
	req_t              req;
	logic              in_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = seq_idle;
	assign req      = '{func: s_tuser[0], request_size: s_tdata[23:0],
		release_addr: s_tdata[47:24]};
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= '1;
		end else if (cfg_we) begin
			heap_limit_q <= cfg_wdata;
		end
	end

	ffba_seq #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ALIGN_BYTES(ALIGN_BYTES),
		.HDR_BYTES  (HDR_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_xfer),
		.req       (req),
		.heap_limit(heap_limit_q),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
			out_q      <= rsp;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q.payload_addr;
	assign m_tuser  = out_q.status;

	`FFBA_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_xfer, !s_tready, "second request taken while busy")

endmodule

`default_nettype wire

// ===== bench/ffba_checker.sv =====
// Response checker for the first-fit block allocator: keeps its own copy of the
// block table, predicts every response and compares it with the master stream.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_checker
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
	parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
	parameter int HDR_BYTES   = DEF_HDR_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,   // request_size[23:0], release_addr[47:24]
	input  wire logic [0:0]  s_tuser,   // func[0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,   // payload_addr[23:0]
	input  wire logic [1:0]  m_tuser,   // status[1:0]
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata,
	output int               mismatches,
	output int               outstanding
);

	logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
	logic              blk_free [MAX_BLOCKS];
	int                blk_count;
	longint            heap_top;
	logic [SIZE_W-1:0] heap_limit;
	rsp_t              predicted_rsp_q[$];

	function automatic longint round_up(longint x);
		return ((x + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	endfunction

	function automatic void remove_block(int j);
		for (int k = j; k < blk_count - 1; k++) begin
			blk_size[k] = blk_size[k + 1];
			blk_free[k] = blk_free[k + 1];
		end
		blk_count--;
	endfunction

	function automatic rsp_t heap_response(logic func, logic [SIZE_W-1:0] size,
			logic [SIZE_W-1:0] addr);
		rsp_t   rsp;
		longint need;
		longint total;
		longint off;
		int     i;
		rsp.payload_addr = '0;
		rsp.status       = ST_OK;
		off              = 0;
		if (func == FUNC_ALLOC) begin
			if (size == '0) begin
				rsp.status = ST_NOOP;
				return rsp;
			end
			need = round_up(longint'(size));
			for (i = 0; i < blk_count; i++) begin
				if (blk_free[i] && longint'(blk_size[i]) >= need) begin
					blk_free[i]      = 1'b0;
					rsp.payload_addr = SIZE_W'(off + HDR_BYTES);
					return rsp;
				end
				off += HDR_BYTES + longint'(blk_size[i]);
			end
			total = round_up(need + HDR_BYTES);
			if (blk_count >= MAX_BLOCKS || heap_top + total > longint'(heap_limit)) begin
				rsp.status = ST_NOMEM;
				return rsp;
			end
			blk_size[blk_count] = SIZE_W'(total - HDR_BYTES);
			blk_free[blk_count] = 1'b0;
			blk_count++;
			rsp.payload_addr = SIZE_W'(heap_top + HDR_BYTES);
			heap_top += total;
			return rsp;
		end
		if (addr == '0) begin
			rsp.status = ST_NOOP;
			return rsp;
		end
		for (i = 0; i < blk_count; i++) begin
			if (off + HDR_BYTES == longint'(addr))
				break;
			off += HDR_BYTES + longint'(blk_size[i]);
		end
		if (i >= blk_count) begin
			rsp.status = ST_BADADDR;
			return rsp;
		end
		blk_free[i] = 1'b1;
		// absorb free successors, then fold into a free predecessor
		while (i + 1 < blk_count && blk_free[i + 1]) begin
			blk_size[i] = SIZE_W'(longint'(blk_size[i]) + HDR_BYTES + longint'(blk_size[i + 1]));
			remove_block(i + 1);
		end
		if (i > 0 && blk_free[i - 1]) begin
			blk_size[i - 1] = SIZE_W'(longint'(blk_size[i - 1]) + HDR_BYTES
				+ longint'(blk_size[i]));
			remove_block(i);
		end
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			blk_count  = 0;
			heap_top   = 0;
			heap_limit = '1;
			mismatches = 0;
			predicted_rsp_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				heap_limit = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (predicted_rsp_q.size() == 0) begin
					$error("unexpected response: payload_addr %0d status %0d", m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = predicted_rsp_q.pop_front();
					if (m_tdata !== want.payload_addr) begin
						$error("payload_addr mismatch: expected %0d, actual %0d",
							want.payload_addr, m_tdata);
						mismatches++;
					end
					if (m_tuser !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predicted_rsp_q.push_back(heap_response(s_tuser[0], s_tdata[SIZE_W-1:0],
					s_tdata[2*SIZE_W-1:SIZE_W]));
			outstanding <= predicted_rsp_q.size();
		end
	end

endmodule

// ===== bench/tb_first_fit_block_allocator_top.sv =====
// Top of the allocator bench: drives requests, heap limit writes and result
// back-pressure, and reports the verdict from the response checker.
// Depends on ffba_pkg, first_fit_block_allocator_top and ffba_checker.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_top;
	import ffba_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int ALIGN_BYTES_STEP = DEF_ALIGN_BYTES;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [47:0]       s_tdata;
	logic [0:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;
	logic [1:0]        m_tuser;
	logic              cfg_we;
	logic [23:0]       cfg_wdata;
	int                mismatches;
	int                outstanding;
	int                cycles = 0;
	int unsigned       stall_left = 0;
	logic              idling = 1'b1;
	logic [SIZE_W-1:0] live_addrs[$];

	first_fit_block_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ffba_checker rsp_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// hold off results in bursts; keep granted addresses for later releases
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready && m_tuser == ST_OK && m_tdata != '0)
				live_addrs.push_back(m_tdata);
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 8);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_request(logic func, logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] addr);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {addr, size};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_heap_limit(logic [SIZE_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_request();
		int unsigned       pick;
		int unsigned       k;
		int unsigned       idx;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] addr;
		size = SIZE_W'($urandom);
		addr = SIZE_W'($urandom);
		pick = $urandom_range(0, 99);
		k    = $urandom_range(0, 99);
		if (pick < 55) begin
			if (k < 3)
				size = '0;
			else if (k < 8)
				size = SIZE_W'($urandom);
			else if (k < 20)
				size = SIZE_W'($urandom_range(1, 64) * ALIGN_BYTES_STEP);
			else if (k < 30)
				size = SIZE_W'($urandom_range(257, 4096));
			else
				size = SIZE_W'($urandom_range(1, 256));
			send_request(FUNC_ALLOC, size, addr);
		end else begin
			if (live_addrs.size() > 0 && k < 80) begin
				idx  = $urandom_range(0, live_addrs.size() - 1);
				addr = live_addrs[idx];
				// keep some addresses to release them twice
				if ($urandom_range(0, 9) != 0)
					live_addrs.delete(idx);
				if (k >= 72)
					addr = addr + SIZE_W'($urandom_range(1, 48));
			end else if (k < 85) begin
				addr = '0;
			end
			send_request(FUNC_FREE, size, addr);
		end
	endtask

	task automatic random_phase(logic [SIZE_W-1:0] limit_value, int items, int calm_tail);
		set_heap_limit(limit_value);
		for (int n = 0; n < items; n++) begin
			idling <= (n < items - calm_tail);
			random_request();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_heap_limit(24'hFFFFFF);
		send_request(FUNC_ALLOC, 24'd0, 24'hFFFFFF);
		send_request(FUNC_FREE, 24'hFFFFFF, 24'd0);
		send_request(FUNC_FREE, 24'd0, 24'hFFFFFF);
		send_request(FUNC_ALLOC, 24'hFFFFFF, 24'd0);
		send_request(FUNC_ALLOC, 24'd1, 24'd0);
		send_request(FUNC_ALLOC, 24'd16, 24'd0);
		send_request(FUNC_ALLOC, 24'd17, 24'd0);
		send_request(FUNC_ALLOC, 24'd100, 24'd0);
		send_request(FUNC_FREE, 24'd0, 24'd32);
		send_request(FUNC_FREE, 24'd0, 24'd32);
		send_request(FUNC_FREE, 24'd0, 24'd33);
		send_request(FUNC_ALLOC, 24'd16, 24'd0);
		send_request(FUNC_FREE, 24'd0, 24'd80);
		send_request(FUNC_FREE, 24'd0, 24'd192);
		send_request(FUNC_FREE, 24'd0, 24'd128);
		send_request(FUNC_ALLOC, 24'd200, 24'd0);
		send_request(FUNC_FREE, 24'd0, 24'd192);

		random_phase(24'h000000, 150, 0);
		random_phase(24'h001000, 400, 0);
		random_phase(24'h080000, 900, 0);
		random_phase(24'hFFFFFF, 550, 250);

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ram.sv
hw/rtl/ffba_align.sv
hw/rtl/ffba_seq.sv
hw/rtl/first_fit_block_allocator_top.sv
bench/ffba_checker.sv
bench/tb_first_fit_block_allocator_top.sv
